>>> design/fedl_pkg.sv
// Shared types, widths and constants for the feedback echo delay line.
// Used by the store RAM, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package fedl_pkg;

  // The store depth must be a power of two; pointers wrap by truncation.
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [DELAY_W-1:0]         delay_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_PASS_GAIN        = cfg_idx_t'(0);
  localparam cfg_idx_t REG_ECHO_GAIN        = cfg_idx_t'(1);
  localparam cfg_idx_t REG_FEEDBACK_GAIN    = cfg_idx_t'(2);
  localparam cfg_idx_t REG_FEEDFORWARD_GAIN = cfg_idx_t'(3);
  localparam cfg_idx_t REG_ECHO_DELAY       = cfg_idx_t'(4);

  // Reset values of the configuration registers (gains are Q2.14).
  localparam gain_t  PASS_GAIN_RST        = gain_t'(16384);
  localparam gain_t  ECHO_GAIN_RST        = gain_t'(8192);
  localparam gain_t  FEEDBACK_GAIN_RST    = gain_t'(8192);
  localparam gain_t  FEEDFORWARD_GAIN_RST = gain_t'(0);
  localparam delay_t ECHO_DELAY_RST       = delay_t'(1024);

  // Stage strobes from the controller to the datapath.
  typedef struct packed {
    logic ld_x;
    logic ld_mul;
    logic ld_sum;
    logic ld_echo;
    logic ld_y;
    logic ld_fb;
    logic ld_out;
    logic same_entry;
  } ctl_t;

endpackage

>>> design/fedl_store_ram.sv
// Delay store: one write port and one read port, read data registered.
// Depends on fedl_pkg for depth and widths.
`timescale 1ns / 1ps

module fedl_store_ram (
  input  logic            clk,
  input  logic            we,
  input  fedl_pkg::addr_t waddr,
  input  fedl_pkg::sample_t wdata,
  input  logic            re,
  input  fedl_pkg::addr_t raddr,
  output fedl_pkg::sample_t rdata
);

  fedl_pkg::sample_t mem [fedl_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/fedl_ctrl.sv
// Sequencer for the echo: clearing sweep, pointers, store access and output handshake.
// Depends on fedl_pkg for types and the stage strobe struct.
`timescale 1ns / 1ps

module fedl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fedl_pkg::delay_t  echo_delay,
  input  fedl_pkg::sample_t sw2,
  output fedl_pkg::ctl_t    ctl,
  output logic              mem_we,
  output fedl_pkg::addr_t   mem_waddr,
  output fedl_pkg::sample_t mem_wdata,
  output logic              mem_re,
  output fedl_pkg::addr_t   mem_raddr
);

  localparam int SUM_W =
    ((fedl_pkg::ADDR_W > fedl_pkg::DELAY_W) ? fedl_pkg::ADDR_W : fedl_pkg::DELAY_W) + 1;
  localparam fedl_pkg::addr_t LAST_ADDR = fedl_pkg::addr_t'(fedl_pkg::STORE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MUL, S_SUM, S_ECHO, S_Y, S_FB, S_WB
  } state_t;

  state_t          state;
  fedl_pkg::addr_t clr_addr;
  fedl_pkg::addr_t rd_ptr;
  fedl_pkg::addr_t w_addr;
  logic            same;

  logic             accept;
  logic             out_free;
  logic [SUM_W-1:0] w_sum;
  fedl_pkg::addr_t  w_comb;

  assign w_sum    = SUM_W'(rd_ptr) + SUM_W'(echo_delay);
  assign w_comb   = w_sum[fedl_pkg::ADDR_W-1:0];
  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rd_ptr    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.ld_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            w_addr <= w_comb;
            same   <= (w_comb == rd_ptr);
            state  <= S_MUL;
          end
        end
        S_MUL:  state <= S_SUM;
        S_SUM:  state <= S_ECHO;
        S_ECHO: state <= S_Y;
        S_Y:    state <= S_FB;
        S_FB:   state <= S_WB;
        S_WB: begin
          if (out_free) begin
            rd_ptr <= rd_ptr + 1'b1;
            state  <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    ctl.ld_x       = accept;
    ctl.ld_mul     = (state == S_MUL);
    ctl.ld_sum     = (state == S_SUM);
    ctl.ld_echo    = (state == S_ECHO);
    ctl.ld_y       = (state == S_Y);
    ctl.ld_fb      = (state == S_FB);
    ctl.ld_out     = (state == S_WB) && out_free;
    ctl.same_entry = same;
  end

  // The write position is read first, then the read position.
  assign mem_re    = accept || (state == S_MUL);
  assign mem_raddr = (state == S_MUL) ? rd_ptr : w_comb;

  // When both positions coincide, the zero written at the read position is final.
  assign mem_we = (state == S_CLEAR) || (state == S_ECHO) ||
                  ((state == S_WB) && out_free && !same);

  always_comb begin
    case (state)
      S_CLEAR: mem_waddr = clr_addr;
      S_ECHO:  mem_waddr = rd_ptr;
      default: mem_waddr = w_addr;
    endcase
  end

  assign mem_wdata = (state == S_WB) ? sw2 : '0;

endmodule

>>> design/fedl_datapath.sv
// Fixed-point arithmetic of the echo: gain products, rounding, saturation, output register.
// Depends on fedl_pkg for sample and gain types and the stage strobe struct.
`timescale 1ns / 1ps

module fedl_datapath (
  input  logic              clk,
  input  fedl_pkg::ctl_t    ctl,
  input  fedl_pkg::sample_t sample_in,
  input  fedl_pkg::gain_t   pass_gain,
  input  fedl_pkg::gain_t   echo_gain,
  input  fedl_pkg::gain_t   feedback_gain,
  input  fedl_pkg::gain_t   feedforward_gain,
  input  fedl_pkg::sample_t rd_data,
  output fedl_pkg::sample_t sw2,
  output fedl_pkg::sample_t sample_out
);

  localparam int PROD_W = fedl_pkg::SAMPLE_W + fedl_pkg::GAIN_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int FRAC_W = 14;
  localparam int SCL_W  = ACC_W - FRAC_W;
  localparam int SUM_W  = SCL_W + 1;
  localparam int ROUND  = 1 << (FRAC_W - 1);
  localparam fedl_pkg::sample_t SAMPLE_MAX = {1'b0, {(fedl_pkg::SAMPLE_W-1){1'b1}}};
  localparam fedl_pkg::sample_t SAMPLE_MIN = {1'b1, {(fedl_pkg::SAMPLE_W-1){1'b0}}};

  // Round half up, then drop the fraction bits (arithmetic shift).
  function automatic logic signed [SCL_W-1:0] scale14(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + ACC_W'(ROUND);
    return t[ACC_W-1:FRAC_W];
  endfunction

  function automatic fedl_pkg::sample_t sat16(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-fedl_pkg::SAMPLE_W:0] top;
    top = v[SUM_W-1:fedl_pkg::SAMPLE_W-1];
    if ((&top) || !(|top)) begin
      return v[fedl_pkg::SAMPLE_W-1:0];
    end else if (v[SUM_W-1]) begin
      return SAMPLE_MIN;
    end else begin
      return SAMPLE_MAX;
    end
  endfunction

  fedl_pkg::sample_t x;
  fedl_pkg::sample_t sw;
  fedl_pkg::sample_t sw1;
  fedl_pkg::sample_t sr;
  fedl_pkg::sample_t y;
  logic signed [PROD_W-1:0] p_ff;
  logic signed [PROD_W-1:0] p_pass;
  logic signed [PROD_W-1:0] p_echo;
  logic signed [PROD_W-1:0] p_fb;

  fedl_pkg::sample_t       s_r;
  logic signed [ACC_W-1:0] y_acc;
  fedl_pkg::sample_t       sw1_next;
  fedl_pkg::sample_t       y_next;

  assign s_r      = ctl.same_entry ? sw1 : sr;
  assign sw1_next = sat16(SUM_W'(sw) + SUM_W'(scale14(ACC_W'(p_ff))));
  assign y_acc    = ACC_W'(p_pass) + ACC_W'(p_echo);
  assign y_next   = sat16(SUM_W'(scale14(y_acc)));
  assign sw2      = sat16(SUM_W'(sw1) + SUM_W'(scale14(ACC_W'(p_fb))));

  always_ff @(posedge clk) begin
    if (ctl.ld_x) begin
      x <= sample_in;
    end
    if (ctl.ld_mul) begin
      sw     <= rd_data;
      p_ff   <= PROD_W'(feedforward_gain) * PROD_W'(x);
      p_pass <= PROD_W'(pass_gain) * PROD_W'(x);
    end
    if (ctl.ld_sum) begin
      sr  <= rd_data;
      sw1 <= sw1_next;
    end
    if (ctl.ld_echo) begin
      p_echo <= PROD_W'(echo_gain) * PROD_W'(s_r);
    end
    if (ctl.ld_y) begin
      y <= y_next;
    end
    if (ctl.ld_fb) begin
      p_fb <= PROD_W'(feedback_gain) * PROD_W'(y);
    end
    if (ctl.ld_out) begin
      sample_out <= y;
    end
  end

endmodule

>>> design/feedback_echo_delay_line.sv
// Top level of the feedback echo delay line; holds the configuration registers.
// Depends on fedl_pkg, fedl_store_ram, fedl_ctrl and fedl_datapath.
// Input channel: in_valid / in_stall with sample_in (signed Q1.15). A beat is taken at a
// rising edge with in_valid high and in_stall low. Output channel: out_valid / out_stall
// with sample_out, one output beat for every input beat, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data. Index 0 is the pass gain,
// 1 the echo gain, 2 the feedback gain, 3 the feedforward gain (all signed Q2.14) and 4 the
// echo delay in samples. Other indexes are ignored. Write only while the block is idle.
// Once a beat is taken the sequencer steps through MUL, SUM, ECHO, Y, FB and WB, loading the
// output register in WB once it is free. One sample is in work at a time, set by the
// read-modify-write sequence on the single write port of the delay store and the chain of
// three dependent multiplies. Reset: synchronous and active high. After reset the block
// sweeps the 4096-entry store to zero, one entry per cycle, and holds in_stall high until
// the sweep is done. Configuration writes are taken during the sweep.
// Stalls: a new input beat is taken while a finished result waits in the output register;
// the sequencer then holds its last step until the output register frees up.
`timescale 1ns / 1ps

module feedback_echo_delay_line (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fedl_pkg::sample_t    sample_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fedl_pkg::sample_t    sample_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  fedl_pkg::cfg_idx_t   cfg_index,
  input  fedl_pkg::cfg_data_t  cfg_data
);

  fedl_pkg::gain_t  pass_gain;
  fedl_pkg::gain_t  echo_gain;
  fedl_pkg::gain_t  feedback_gain;
  fedl_pkg::gain_t  feedforward_gain;
  fedl_pkg::delay_t echo_delay;

  fedl_pkg::ctl_t    ctl;
  fedl_pkg::sample_t sw2;
  logic              mem_we;
  fedl_pkg::addr_t   mem_waddr;
  fedl_pkg::sample_t mem_wdata;
  logic              mem_re;
  fedl_pkg::addr_t   mem_raddr;
  fedl_pkg::sample_t mem_rdata;

  // The register file always takes a beat outside of reset.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_gain        <= fedl_pkg::PASS_GAIN_RST;
      echo_gain        <= fedl_pkg::ECHO_GAIN_RST;
      feedback_gain    <= fedl_pkg::FEEDBACK_GAIN_RST;
      feedforward_gain <= fedl_pkg::FEEDFORWARD_GAIN_RST;
      echo_delay       <= fedl_pkg::ECHO_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fedl_pkg::REG_PASS_GAIN:        pass_gain        <= fedl_pkg::gain_t'(cfg_data);
        fedl_pkg::REG_ECHO_GAIN:        echo_gain        <= fedl_pkg::gain_t'(cfg_data);
        fedl_pkg::REG_FEEDBACK_GAIN:    feedback_gain    <= fedl_pkg::gain_t'(cfg_data);
        fedl_pkg::REG_FEEDFORWARD_GAIN: feedforward_gain <= fedl_pkg::gain_t'(cfg_data);
        fedl_pkg::REG_ECHO_DELAY:
          echo_delay <= cfg_data[fedl_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // The sequencer owns the pointers, the clearing sweep and all store traffic.
  fedl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .echo_delay (echo_delay),
    .sw2        (sw2),
    .ctl        (ctl),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr)
  );

  // The datapath follows the stage strobes; it holds no control state.
  fedl_datapath u_datapath (
    .clk              (clk),
    .ctl              (ctl),
    .sample_in        (sample_in),
    .pass_gain        (pass_gain),
    .echo_gain        (echo_gain),
    .feedback_gain    (feedback_gain),
    .feedforward_gain (feedforward_gain),
    .rd_data          (mem_rdata),
    .sw2              (sw2),
    .sample_out       (sample_out)
  );

  fedl_store_ram u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second input beat taken while a sample is in work");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("store read and write hit the same entry in one cycle");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.ld_out |-> (!out_valid || !out_stall))
    else $error("output register loaded over a result not yet taken");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.ld_out |=> out_valid)
    else $error("loaded result not presented on the output");
`endif

endmodule

>>> dv/feedback_echo_delay_line_checker.sv
// Checker for the feedback echo delay line: watches the config, input and output channels,
// predicts each output sample from its own gains, delay store and read pointer, and compares.
// Depends on fedl_pkg only.
`timescale 1ns / 1ps

module feedback_echo_delay_line_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  fedl_pkg::sample_t   sample_in,
  input  logic                out_valid,
  input  logic                out_stall,
  input  fedl_pkg::sample_t   sample_out,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  fedl_pkg::cfg_idx_t  cfg_index,
  input  fedl_pkg::cfg_data_t cfg_data,
  output int unsigned         mismatches,
  output int unsigned         outstanding,
  output int unsigned         results_seen
);
  import fedl_pkg::*;

  localparam int REPORT_LIMIT = 10;

  gain_t   pass_g;
  gain_t   echo_g;
  gain_t   fb_g;
  gain_t   ff_g;
  delay_t  echo_dly;
  sample_t delay_mem [STORE_DEPTH];
  addr_t   rd_ptr;
  sample_t expected_out [$];

  // Q2.14 product back to Q1.15: add half an LSB, then floor by the arithmetic shift.
  function automatic longint round_q14(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic sample_t clamp16(longint v);
    if (v > 32767) return sample_t'(16'sh7fff);
    if (v < -32768) return sample_t'(16'sh8000);
    return sample_t'(v);
  endfunction

  // Runs one sample through the echo and returns the sample it should produce. The write
  // position may equal the read position when the delay is zero; the order below handles it.
  function automatic sample_t echo_step(sample_t x);
    int      wr;
    sample_t y;
    wr = (int'(rd_ptr) + int'(echo_dly)) % STORE_DEPTH;
    delay_mem[wr] = clamp16(longint'(delay_mem[wr]) + round_q14(longint'(ff_g) * longint'(x)));
    y = clamp16(round_q14(longint'(pass_g) * longint'(x) +
                          longint'(echo_g) * longint'(delay_mem[rd_ptr])));
    delay_mem[wr] = clamp16(longint'(delay_mem[wr]) + round_q14(longint'(fb_g) * longint'(y)));
    delay_mem[rd_ptr] = '0;
    rd_ptr = addr_t'(rd_ptr + 1'b1);
    return y;
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      pass_g   = PASS_GAIN_RST;
      echo_g   = ECHO_GAIN_RST;
      fb_g     = FEEDBACK_GAIN_RST;
      ff_g     = FEEDFORWARD_GAIN_RST;
      echo_dly = ECHO_DELAY_RST;
      rd_ptr   = '0;
      foreach (delay_mem[i]) delay_mem[i] = '0;
      expected_out.delete();
      mismatches   = 0;
      outstanding  = 0;
      results_seen = 0;
    end else begin
      // Compare before predicting so an output beat is never matched to an input beat
      // taken on the same edge.
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("[%0t] output beat %0d arrived with nothing pending: got %0d",
                     $time, results_seen, sample_out);
        end else begin
          want = expected_out.pop_front();
          if (sample_out !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("[%0t] output beat %0d sample_out: expected %0d, got %0d",
                       $time, results_seen, want, sample_out);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PASS_GAIN:        pass_g   = gain_t'(cfg_data);
          REG_ECHO_GAIN:        echo_g   = gain_t'(cfg_data);
          REG_FEEDBACK_GAIN:    fb_g     = gain_t'(cfg_data);
          REG_FEEDFORWARD_GAIN: ff_g     = gain_t'(cfg_data);
          REG_ECHO_DELAY:       echo_dly = delay_t'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_out.push_back(echo_step(sample_in));
      outstanding = expected_out.size();
    end
  end

endmodule

>>> dv/feedback_echo_delay_line_tb.sv
// Testbench top for the feedback echo delay line: drives reset, register writes, input beats
// and output back-pressure, and prints the verdict.
// Depends on fedl_pkg, feedback_echo_delay_line and feedback_echo_delay_line_checker.
`timescale 1ns / 1ps

module feedback_echo_delay_line_tb;
  import fedl_pkg::*;

  localparam int RANDOM_BLOCKS = 6;
  localparam int BLOCK_SAMPLES = 300;
  localparam int HOLD_CYCLES   = 400;
  // Extra quiet time once every predicted output has come out.
  localparam int DRAIN_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 1_000_000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  sample_t   sample_in = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sample_t   sample_out;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_data  = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned samples_sent  = 0;
  int unsigned settings_used = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_go       = 1'b0;
  logic        holding       = 1'b0;

  // Directed samples. The first set runs with a short delay so that the first beats come
  // back as echoes inside the set; the other two use saturating gains at zero delay and at
  // the longest delay.
  int corner_vals [8] = '{32767, -32768, 0, 1, -1, 21845, -21846, 12345};
  int zero_dly_vals [8] = '{32767, 32767, -32768, -32768, 100, -100, 0, 1};
  int long_dly_vals [6] = '{-32768, 32767, -1, 1, 16384, -16384};

  always #1 clk = ~clk;

  feedback_echo_delay_line DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  feedback_echo_delay_line_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  // Output back-pressure. Inputs only ever change on the falling edge, so the block and
  // the checker both see settled values at the rising edge.
  always @(negedge clk) begin
    out_stall <= holding || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // One long hold-off on the output side. The sender keeps offering beats meanwhile, so the
  // block has to fill its output register, take one more beat and then stall its input.
  initial begin
    @(posedge hold_go);
    @(posedge clk);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped after %0d cycles with %0d output beats still pending.",
             CYCLE_LIMIT, outstanding);
    $display("status: fail");
    $finish;
  end

  // Issues one register write and returns at the falling edge after the beat. cfg_valid
  // stays high so that back-to-back writes never lower and raise it in the same step.
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Writes every register once, sometimes preceded by a write to an unused index that the
  // block must ignore. The delay word may carry upper bits that must be dropped.
  task automatic apply_setting(input gain_t pass_g, input gain_t echo_g, input gain_t fb_g,
                               input gain_t ff_g, input cfg_data_t dly_word);
    if ($urandom_range(0, 1) == 1)
      write_reg(cfg_idx_t'($urandom_range(int'(REG_ECHO_DELAY) + 1, 2**CFG_IDX_W - 1)),
                cfg_data_t'($urandom));
    write_reg(REG_PASS_GAIN,        cfg_data_t'(pass_g));
    write_reg(REG_ECHO_GAIN,        cfg_data_t'(echo_g));
    write_reg(REG_FEEDBACK_GAIN,    cfg_data_t'(fb_g));
    write_reg(REG_FEEDFORWARD_GAIN, cfg_data_t'(ff_g));
    write_reg(REG_ECHO_DELAY,       dly_word);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Offers one sample, idling first at the current sender rate. Returns at the falling edge
  // after the beat with in_valid still high; the next call or a drain decides its next value.
  task automatic send_sample(input sample_t x);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    samples_sent++;
  endtask

  // Waits until every predicted sample has come out and the block has gone quiet, so that
  // the registers may be rewritten.
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Gains: full-scale extremes, moderate positive and negative values, and raw random words.
  function automatic gain_t pick_gain();
    case ($urandom_range(0, 5))
      0: return gain_t'(16'sh7fff);
      1: return gain_t'(16'sh8000);
      2: return gain_t'($urandom_range(0, 16384));
      3: return gain_t'(-int'($urandom_range(0, 16384)));
      default: return gain_t'($urandom);
    endcase
  endfunction

  // Delays are mostly short so that echoes and feedback build up within a block of samples.
  function automatic cfg_data_t pick_delay_word();
    cfg_data_t w;
    delay_t    d;
    case ($urandom_range(0, 7))
      0: d = '0;
      1: d = '1;
      2: d = delay_t'($urandom);
      default: d = delay_t'($urandom_range(1, 24));
    endcase
    w = cfg_data_t'($urandom);
    w[DELAY_W-1:0] = d;
    return w;
  endfunction

  // Input samples: rails, quiet signal near zero, and full-range noise.
  function automatic sample_t audio_sample();
    case ($urandom_range(0, 7))
      0: return sample_t'(16'sh7fff);
      1: return sample_t'(16'sh8000);
      2: return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    // Synchronous reset first. After it the block sweeps its store and
    // stalls input beats; register writes are accepted during the sweep.
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every unused index gets a write that must leave the registers alone.
    for (int k = int'(REG_ECHO_DELAY) + 1; k < 2**CFG_IDX_W; k++)
      write_reg(cfg_idx_t'(k), cfg_data_t'($urandom));

    // Unity feedforward and a delay of three, written with junk in the upper data bits.
    apply_setting(gain_t'(16384), gain_t'(8192), gain_t'(8192), gain_t'(16384), 16'hf003);
    foreach (corner_vals[i]) send_sample(sample_t'(corner_vals[i]));

    // Zero delay: read and write hit the same entry, so the feedforward term is heard at
    // once. The delay word only has upper bits set, which must read back as zero.
    settle();
    apply_setting(gain_t'(16'sh8000), gain_t'(16'sh7fff), gain_t'(16'sh8000),
                  gain_t'(16'sh7fff), 16'hf000);
    foreach (zero_dly_vals[i]) send_sample(sample_t'(zero_dly_vals[i]));

    // Longest delay with the opposite rails on every gain.
    settle();
    apply_setting(gain_t'(16'sh7fff), gain_t'(16'sh8000), gain_t'(16'sh7fff),
                  gain_t'(16'sh8000), 16'h0fff);
    foreach (long_dly_vals[i]) send_sample(sample_t'(long_dly_vals[i]));

    // Random part, one fresh setting per block. The first two blocks idle the sender
    // lightly and the receiver heavily, the next two the other way round, and the last two
    // run without idling; the long output hold-off starts with the fifth block.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      settle();
      if (blk < 2) begin
        send_idle_pct = 30;
        recv_idle_pct <= 85;
      end else if (blk < 4) begin
        send_idle_pct = 85;
        recv_idle_pct <= 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_delay_word());
      if (blk == 4) hold_go <= 1'b1;
      repeat (BLOCK_SAMPLES) send_sample(audio_sample());
    end

    settle();
    $display("Checked %0d output beats from %0d input beats across %0d register settings,",
             results_seen, samples_sent, settings_used);
    $display("with zero and full-length delays, rail gains and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/fedl_pkg.sv
design/fedl_store_ram.sv
design/fedl_ctrl.sv
design/fedl_datapath.sv
design/feedback_echo_delay_line.sv
dv/feedback_echo_delay_line_checker.sv
dv/feedback_echo_delay_line_tb.sv
